/* sv/bmt_pkg.sv */
// ----------------------------------------------------------------------------
// bmt_pkg
// Shared types, codes and constants of the buzzer mode timer.
// ----------------------------------------------------------------------------
package bmt_pkg;

    localparam int TIMER_BITS_DEFAULT = 16;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_ALARM_ON  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ALARM_OFF = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ACTIVE_HI = 2'd2;

    localparam logic [15:0] ALARM_ON_RESET  = 16'd500;
    localparam logic [15:0] ALARM_OFF_RESET = 16'd500;
    localparam logic        ACTIVE_HI_RESET = 1'b1;

    localparam logic [15:0] BEEP_MIN_MS = 16'd50;
    localparam logic [15:0] BEEP_MAX_MS = 16'd5000;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_POWER = 2'd1,
        ACT_BEEP  = 2'd2,
        ACT_ALARM = 2'd3
    } action_t;

    typedef struct packed {
        action_t     action;
        logic        on_flag;
        logic [15:0] beep_ms;
    } cmd_t;

    typedef struct packed {
        logic sounding;
        logic pin_level;
    } res_t;

    typedef struct packed {
        logic [15:0] alarm_on_ms;
        logic [15:0] alarm_off_ms;
        logic        active_high;
    } cfg_t;

endpackage

/* sv/bmt_cfg.sv */
// ----------------------------------------------------------------------------
// bmt_cfg
// Configuration registers written through the plain write port.
// ----------------------------------------------------------------------------
module bmt_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bmt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bmt_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    output bmt_pkg::cfg_t                      cfg
);
    import bmt_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ALARM_ON:  cfg_next.alarm_on_ms  = cfg_wdata[15:0];
                CFG_ALARM_OFF: cfg_next.alarm_off_ms = cfg_wdata[15:0];
                CFG_ACTIVE_HI: cfg_next.active_high  = cfg_wdata[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alarm_on_ms  <= ALARM_ON_RESET;
            cfg_reg.alarm_off_ms <= ALARM_OFF_RESET;
            cfg_reg.active_high  <= ACTIVE_HI_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/bmt_in_stage.sv */
// ----------------------------------------------------------------------------
// bmt_in_stage
// Input register holding one accepted request until the core takes it.
// ----------------------------------------------------------------------------
module bmt_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  bmt_pkg::cmd_t cmd,
    output logic          held_valid,
    output bmt_pkg::cmd_t held_cmd,
    input  logic          take
);
    import bmt_pkg::*;

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;

    assign cmd_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd_ready)
        begin
            valid_next = cmd_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            cmd_reg <= cmd;
        end
    end

    assign held_valid = valid_reg;
    assign held_cmd   = cmd_reg;

endmodule

/* sv/bmt_core.sv */
// ----------------------------------------------------------------------------
// bmt_core
// Mode state of the buzzer and its combinational update for one request.
// ----------------------------------------------------------------------------
module bmt_core #(
    parameter int TIMER_BITS = bmt_pkg::TIMER_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  bmt_pkg::cmd_t cmd,
    input  bmt_pkg::cfg_t cfg,
    output bmt_pkg::res_t res
);
    import bmt_pkg::*;

    localparam logic [32:0] TIMER_MAX_W = (33'd1 << TIMER_BITS) - 33'd1;

    logic                  sound_now_reg;
    logic                  sound_now_next;
    logic                  alarm_mode_reg;
    logic                  alarm_mode_next;
    logic                  alarm_phase_reg;
    logic                  alarm_phase_next;
    logic                  beep_mode_reg;
    logic                  beep_mode_next;
    logic [TIMER_BITS-1:0] remaining_reg;
    logic [TIMER_BITS-1:0] remaining_next;

    logic [15:0]           beep_len;
    logic [15:0]           on_len;
    logic [15:0]           off_len;
    logic [TIMER_BITS-1:0] beep_load;
    logic [TIMER_BITS-1:0] on_load;
    logic [TIMER_BITS-1:0] off_load;
    logic                  expired;

    // saturate a 16-bit length into the counter width
    function automatic logic [TIMER_BITS-1:0] sat_load(input logic [15:0] v);
        logic [32:0] wide;
        wide = {17'd0, v};
        if (wide > TIMER_MAX_W)
        begin
            wide = TIMER_MAX_W;
        end
        return wide[TIMER_BITS-1:0];
    endfunction

    always_comb
    begin
        beep_len = cmd.beep_ms;
        if (beep_len < BEEP_MIN_MS)
        begin
            beep_len = BEEP_MIN_MS;
        end
        if (beep_len > BEEP_MAX_MS)
        begin
            beep_len = BEEP_MAX_MS;
        end
        // a phase length of zero behaves as one
        on_len  = (cfg.alarm_on_ms  == 16'd0) ? 16'd1 : cfg.alarm_on_ms;
        off_len = (cfg.alarm_off_ms == 16'd0) ? 16'd1 : cfg.alarm_off_ms;
    end

    assign beep_load = sat_load(beep_len);
    assign on_load   = sat_load(on_len);
    assign off_load  = sat_load(off_len);
    assign expired   = (remaining_reg == '0) || (remaining_reg == TIMER_BITS'(1));

    always_comb
    begin
        sound_now_next   = sound_now_reg;
        alarm_mode_next  = alarm_mode_reg;
        alarm_phase_next = alarm_phase_reg;
        beep_mode_next   = beep_mode_reg;
        remaining_next   = remaining_reg;
        case (cmd.action)
            ACT_TICK:
            begin
                if (beep_mode_reg)
                begin
                    if (expired)
                    begin
                        remaining_next = '0;
                        beep_mode_next = 1'b0;
                        sound_now_next = 1'b0;
                    end
                    else
                    begin
                        remaining_next = remaining_reg - TIMER_BITS'(1);
                    end
                end
                else if (alarm_mode_reg)
                begin
                    if (expired)
                    begin
                        alarm_phase_next = !alarm_phase_reg;
                        remaining_next   = alarm_phase_reg ? off_load : on_load;
                        sound_now_next   = !alarm_phase_reg;
                    end
                    else
                    begin
                        remaining_next = remaining_reg - TIMER_BITS'(1);
                    end
                end
            end
            ACT_POWER:
            begin
                beep_mode_next  = 1'b0;
                alarm_mode_next = 1'b0;
                sound_now_next  = cmd.on_flag;
            end
            ACT_BEEP:
            begin
                alarm_mode_next = 1'b0;
                beep_mode_next  = 1'b1;
                remaining_next  = beep_load;
                sound_now_next  = 1'b1;
            end
            ACT_ALARM:
            begin
                // same value as now leaves everything alone, even a running beep
                if (cmd.on_flag != alarm_mode_reg)
                begin
                    alarm_mode_next = cmd.on_flag;
                    beep_mode_next  = 1'b0;
                    sound_now_next  = cmd.on_flag;
                    if (cmd.on_flag)
                    begin
                        alarm_phase_next = 1'b1;
                        remaining_next   = on_load;
                    end
                end
            end
            default:
            begin
                sound_now_next = sound_now_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sound_now_reg   <= 1'b0;
            alarm_mode_reg  <= 1'b0;
            alarm_phase_reg <= 1'b0;
            beep_mode_reg   <= 1'b0;
            remaining_reg   <= '0;
        end
        else if (take)
        begin
            sound_now_reg   <= sound_now_next;
            alarm_mode_reg  <= alarm_mode_next;
            alarm_phase_reg <= alarm_phase_next;
            beep_mode_reg   <= beep_mode_next;
            remaining_reg   <= remaining_next;
        end
    end

    assign res.sounding  = sound_now_next;
    assign res.pin_level = sound_now_next ? cfg.active_high : !cfg.active_high;

endmodule

/* sv/bmt_out_stage.sv */
// ----------------------------------------------------------------------------
// bmt_out_stage
// Result register holding one result until the receiver takes it.
// ----------------------------------------------------------------------------
module bmt_out_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load_valid,
    output logic          load_ready,
    input  bmt_pkg::res_t load_res,
    output logic          res_valid,
    input  logic          res_ready,
    output bmt_pkg::res_t res
);
    import bmt_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign load_ready = !valid_reg || res_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load_ready)
        begin
            valid_next = load_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            res_reg <= load_res;
        end
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

/* sv/buzzer_mode_timer.sv */
// ----------------------------------------------------------------------------
// buzzer_mode_timer
// Buzzer drive controller: continuous, timed beep and intermittent alarm.
// ----------------------------------------------------------------------------
// Requests arrive on the cmd channel (valid/ready): a 1 ms tick, set power,
// timed beep or set alarm. Each request yields one result on the res channel
// (valid/ready) with the sounding state and the pin level after polarity.
// A request lands in an input register, the mode update runs in combinational
// logic as it moves on, and the result sits in an output register that drives
// res_valid. Throughput is one request per cycle while the receiver keeps up.
// When the receiver stalls, the result register holds and the input register
// still takes one more request; after that cmd_ready drops until res_ready.
// Reset clears the mode state, empties both registers and loads the alarm
// phases with 500 ms and the polarity with active high. The configuration
// port takes a write on any cycle with cfg_we high, and is meant to be used
// while no request is in flight.
// ----------------------------------------------------------------------------
module buzzer_mode_timer #(
    parameter int TIMER_BITS = bmt_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bmt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bmt_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                               cmd_valid,
    output logic                               cmd_ready,
    input  bmt_pkg::cmd_t                      cmd,
    output logic                               res_valid,
    input  logic                               res_ready,
    output bmt_pkg::res_t                      res
);
    import bmt_pkg::*;

    cfg_t cfg;
    cmd_t held_cmd;
    res_t core_res;
    logic held_valid;
    logic load_ready;
    logic take;

    assign take = held_valid && load_ready;

    bmt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bmt_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .held_valid (held_valid),
        .held_cmd   (held_cmd),
        .take       (take)
    );

    bmt_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .cmd   (held_cmd),
        .cfg   (cfg),
        .res   (core_res)
    );

    bmt_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (held_valid),
        .load_ready (load_ready),
        .load_res   (core_res),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

endmodule

/* sv/bmt_checker.sv */
// ----------------------------------------------------------------------------
// bmt_checker
// Port-level checks of the buzzer mode timer, bound to the top level.
// ----------------------------------------------------------------------------
module bmt_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          cfg_we,
    input logic          res_valid,
    input logic          res_ready,
    input bmt_pkg::res_t res
);
    import bmt_pkg::*;

    // reset leaves the result register empty from the next edge on
    property p_reset_empty;
        @(posedge clk) !rst_n |=> !res_valid;
    endproperty
    a_reset_empty: assert property (p_reset_empty)
        else $error("result valid during reset");

    property p_stall_hold;
        @(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res);
    endproperty
    a_stall_hold: assert property (p_stall_hold)
        else $error("stalled result changed or vanished");

    // polarity stays put between results when the port is left alone
    property p_polarity_steady;
        @(posedge clk) disable iff (!rst_n)
        res_valid && $past(res_valid) && $past(rst_n) && $past(rst_n, 2)
            && !$past(cfg_we) && !$past(cfg_we, 2)
        |-> ((res.sounding ^ res.pin_level)
             == $past(res.sounding ^ res.pin_level));
    endproperty
    a_polarity_steady: assert property (p_polarity_steady)
        else $error("pin polarity changed without a configuration write");

endmodule

bind buzzer_mode_timer bmt_checker u_bmt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the buzzer mode timer.
// ----------------------------------------------------------------------------
// A queue of pending requests feeds a valid/ready driver. Each accepted request
// runs through a local model of the buzzer modes, and the predicted levels
// wait in a queue. A monitor compares every result against the oldest
// prediction. Both sides insert random gaps. Between phases the bench drains
// and rewrites the alarm lengths and the polarity, extremes included.
// ----------------------------------------------------------------------------
module tb_top;
    import bmt_pkg::*;

    localparam int LIMIT_CYCLES  = 600000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_ITEMS   = 230;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;
    logic                      cmd_valid = 1'b0;
    logic                      cmd_ready;
    cmd_t                      cmd       = '0;
    logic                      res_valid;
    logic                      res_ready = 1'b0;
    res_t                      res;

    buzzer_mode_timer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    cmd_t pending_cmds[$];
    res_t expected_levels[$];

    // local copy of the registers and mode state
    cfg_t        shadow_cfg;
    logic        tone_on     = 1'b0;
    logic        alarm_armed = 1'b0;
    logic        alarm_loud  = 1'b0;
    logic        beep_active = 1'b0;
    logic [15:0] ms_left     = '0;

    int   mismatches  = 0;
    int   cycle_count = 0;
    int   send_wait   = 0;
    int   recv_wait   = 0;
    logic send_calm   = 1'b0;
    logic recv_calm   = 1'b0;
    res_t got_level;
    res_t want_level;

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [15:0] alarm_span(logic loud);
        logic [15:0] len;
        len = loud ? shadow_cfg.alarm_on_ms : shadow_cfg.alarm_off_ms;
        if (len == 16'd0)
            len = 16'd1;
        return len;
    endfunction

    function automatic logic [15:0] clamp_beep(logic [15:0] d);
        if (d < BEEP_MIN_MS)
            return BEEP_MIN_MS;
        if (d > BEEP_MAX_MS)
            return BEEP_MAX_MS;
        return d;
    endfunction

    // advance the mode state by one request and queue the expected levels
    task automatic advance_buzzer(cmd_t c);
        res_t lv;
        case (c.action)
            ACT_TICK:
            begin
                if (beep_active)
                begin
                    if (ms_left <= 16'd1)
                    begin
                        ms_left     = '0;
                        beep_active = 1'b0;
                        tone_on     = 1'b0;
                    end
                    else
                        ms_left = ms_left - 16'd1;
                end
                else if (alarm_armed)
                begin
                    if (ms_left <= 16'd1)
                    begin
                        alarm_loud = ~alarm_loud;
                        ms_left    = alarm_span(alarm_loud);
                        tone_on    = alarm_loud;
                    end
                    else
                        ms_left = ms_left - 16'd1;
                end
            end
            ACT_POWER:
            begin
                beep_active = 1'b0;
                alarm_armed = 1'b0;
                tone_on     = c.on_flag;
            end
            ACT_BEEP:
            begin
                alarm_armed = 1'b0;
                beep_active = 1'b1;
                ms_left     = clamp_beep(c.beep_ms);
                tone_on     = 1'b1;
            end
            default:
            begin
                // same value again leaves everything alone, even a running beep
                if (c.on_flag != alarm_armed)
                begin
                    alarm_armed = c.on_flag;
                    beep_active = 1'b0;
                    if (c.on_flag)
                    begin
                        alarm_loud = 1'b1;
                        ms_left    = alarm_span(1'b1);
                        tone_on    = 1'b1;
                    end
                    else
                        tone_on = 1'b0;
                end
            end
        endcase
        lv.sounding  = tone_on;
        lv.pin_level = tone_on ? shadow_cfg.active_high : ~shadow_cfg.active_high;
        expected_levels.push_back(lv);
    endtask

    // mostly no gap, some short ones, a few long
    function automatic int gap_len(logic calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            cmd_valid <= 1'b0;
        else
        begin
            if (cmd_valid && cmd_ready)
            begin
                advance_buzzer(cmd);
                if ($urandom_range(0, 39) == 0)
                    send_calm = ~send_calm;
            end
            if (!cmd_valid || cmd_ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait = send_wait - 1;
                    cmd_valid <= 1'b0;
                end
                else if (pending_cmds.size() != 0)
                begin
                    cmd       <= pending_cmds.pop_front();
                    cmd_valid <= 1'b1;
                    send_wait = gap_len(send_calm);
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // monitor and result-side stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            if (res_valid && res_ready)
            begin
                got_level = res;
                if (expected_levels.size() == 0)
                    report_mismatch($sformatf("result %b with no request outstanding",
                                              got_level));
                else
                begin
                    want_level = expected_levels.pop_front();
                    if (got_level.sounding !== want_level.sounding)
                        report_mismatch($sformatf("sounding %b, expected %b",
                                                  got_level.sounding, want_level.sounding));
                    if (got_level.pin_level !== want_level.pin_level)
                        report_mismatch($sformatf("pin_level %b, expected %b",
                                                  got_level.pin_level, want_level.pin_level));
                end
                recv_wait = gap_len(recv_calm);
                if ($urandom_range(0, 39) == 0)
                    recv_calm = ~recv_calm;
            end
            if (recv_wait > 0)
            begin
                recv_wait = recv_wait - 1;
                res_ready <= 1'b0;
            end
            else
                res_ready <= 1'b1;
        end
    end

    task automatic push_cmd(action_t a, logic on, logic [15:0] d);
        cmd_t c;
        c.action  = a;
        c.on_flag = on;
        c.beep_ms = d;
        pending_cmds.push_back(c);
    endtask

    task automatic push_ticks(int n);
        repeat (n) push_cmd(ACT_TICK, 1'($urandom_range(0, 1)), 16'($urandom));
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_ALARM_ON:  shadow_cfg.alarm_on_ms  = val;
            CFG_ALARM_OFF: shadow_cfg.alarm_off_ms = val;
            CFG_ACTIVE_HI: shadow_cfg.active_high  = val[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // sender holds off until every outstanding result is back
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || cmd_valid || expected_levels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly complete beeps and alarm cycles, the rest loose requests
    task automatic queue_random(int target);
        int          n;
        int          pick;
        int          ticks;
        int          span;
        logic [15:0] d;
        n = 0;
        while (n < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                case ($urandom_range(0, 9))
                    0, 1: d = 16'($urandom);
                    2:
                    begin
                        case ($urandom_range(0, 5))
                            0: d = 16'd49;
                            1: d = 16'd50;
                            2: d = 16'd51;
                            3: d = 16'd4999;
                            4: d = 16'd5001;
                            default: d = 16'hFFFF;
                        endcase
                    end
                    default: d = 16'($urandom_range(0, 60));
                endcase
                if (clamp_beep(d) > 16'd80)
                    ticks = $urandom_range(0, 20);
                else
                    ticks = int'(clamp_beep(d)) + $urandom_range(0, 4) - 2;
                push_cmd(ACT_BEEP, 1'($urandom_range(0, 1)), d);
                push_ticks(ticks);
                n += 1 + ticks;
            end
            else if (pick < 65)
            begin
                span = int'(alarm_span(1'b1)) + int'(alarm_span(1'b0));
                if (span > 34)
                    span = 34;
                ticks = $urandom_range(1, 2 * span + 2);
                push_cmd(ACT_ALARM, 1'b1, 16'($urandom));
                push_ticks(ticks);
                n += 1 + ticks;
                case ($urandom_range(0, 3))
                    0: push_cmd(ACT_ALARM, 1'b0, 16'($urandom));
                    1: push_cmd(ACT_POWER, 1'($urandom_range(0, 1)), 16'($urandom));
                    2: push_cmd(ACT_ALARM, 1'b1, 16'($urandom));
                    default: push_cmd(ACT_BEEP, 1'($urandom_range(0, 1)),
                                      16'($urandom_range(0, 60)));
                endcase
                n++;
            end
            else
            begin
                push_cmd(action_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         16'($urandom));
                n++;
            end
        end
    endtask

    initial
    begin
        shadow_cfg.alarm_on_ms  = ALARM_ON_RESET;
        shadow_cfg.alarm_off_ms = ALARM_OFF_RESET;
        shadow_cfg.active_high  = ACTIVE_HI_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed requests under the reset settings
        push_cmd(ACT_TICK,  1'b0, 16'd0);     // tick while idle
        push_cmd(ACT_POWER, 1'b1, 16'd0);
        push_cmd(ACT_TICK,  1'b0, 16'd0);
        push_cmd(ACT_POWER, 1'b0, 16'hFFFF);
        push_cmd(ACT_BEEP,  1'b0, 16'd0);     // clamped up to the minimum
        push_cmd(ACT_TICK,  1'b0, 16'd0);
        push_cmd(ACT_ALARM, 1'b1, 16'd0);     // alarm overrides the beep
        push_cmd(ACT_TICK,  1'b0, 16'd0);
        push_cmd(ACT_ALARM, 1'b1, 16'd0);     // unchanged alarm
        push_cmd(ACT_ALARM, 1'b0, 16'd0);
        push_cmd(ACT_BEEP,  1'b1, 16'd49);
        push_cmd(ACT_ALARM, 1'b0, 16'd0);     // alarm off leaves the beep running
        push_cmd(ACT_TICK,  1'b1, 16'd0);
        push_cmd(ACT_POWER, 1'b1, 16'd0);
        push_cmd(ACT_ALARM, 1'b0, 16'd0);     // power stays on
        push_cmd(ACT_TICK,  1'b0, 16'd0);
        push_cmd(ACT_BEEP,  1'b0, 16'hFFFF);  // clamped down to the maximum
        push_cmd(ACT_BEEP,  1'b0, 16'd5001);
        push_cmd(ACT_BEEP,  1'b0, 16'd5000);
        push_cmd(ACT_BEEP,  1'b1, 16'd50);
        push_cmd(ACT_BEEP,  1'b0, 16'd1);
        push_cmd(ACT_POWER, 1'b0, 16'd0);
        push_cmd(ACT_ALARM, 1'b1, 16'h5555);
        push_cmd(ACT_POWER, 1'b0, 16'hAAAA);  // power overrides the alarm
        push_cmd(ACT_TICK,  1'b0, 16'd0);
        wait_idle();

        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(CFG_ALARM_ON, 16'd1);
                    write_reg(CFG_ALARM_OFF, 16'd1);
                    write_reg(CFG_ACTIVE_HI, 16'd0);
                end
                1:
                begin
                    // zero lengths behave as one
                    write_reg(CFG_ALARM_ON, 16'd0);
                    write_reg(CFG_ALARM_OFF, 16'd0);
                    write_reg(CFG_ACTIVE_HI, 16'd1);
                end
                2:
                begin
                    write_reg(CFG_ALARM_ON, 16'hFFFF);
                    write_reg(CFG_ALARM_OFF, 16'hFFFF);
                    write_reg(CFG_ACTIVE_HI, 16'd0);
                end
                3:
                begin
                    write_reg(CFG_ALARM_ON, 16'd3);
                    write_reg(CFG_ALARM_OFF, 16'd7);
                    write_reg(CFG_ACTIVE_HI, 16'd1);
                end
                4:
                begin
                    write_reg(CFG_ALARM_ON, 16'hFFFF);
                    write_reg(CFG_ALARM_OFF, 16'd1);
                    write_reg(CFG_ACTIVE_HI, 16'd0);
                end
                5:
                begin
                    write_reg(CFG_ALARM_ON, 16'd1);
                    write_reg(CFG_ALARM_OFF, 16'hFFFF);
                    write_reg(CFG_ACTIVE_HI, 16'd1);
                end
                default:
                begin
                    write_reg(CFG_ALARM_ON, 16'($urandom_range(1, 25)));
                    write_reg(CFG_ALARM_OFF, 16'($urandom_range(1, 25)));
                    write_reg(CFG_ACTIVE_HI, 16'($urandom_range(0, 1)));
                end
            endcase
            queue_random(PHASE_ITEMS);
            wait_idle();
        end

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* buzzer_mode_timer.f */
sv/bmt_pkg.sv
sv/bmt_cfg.sv
sv/bmt_in_stage.sv
sv/bmt_core.sv
sv/bmt_out_stage.sv
sv/buzzer_mode_timer.sv
sv/bmt_checker.sv
dv/tb_top.sv
